>>> hw/rtl/lsmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_pkg: shared types and constants for the scan-line mode timer
// Holds the line timing constants, the mode encoding and the state and
// result structures that pass between the timer's modules.
// ----------------------------------------------------------------------------
package lsmt_pkg;

	localparam int unsigned DOT_W  = 9;
	localparam int unsigned LINE_W = 8;
	localparam int unsigned MC_W   = 3;

	localparam logic [DOT_W-1:0]  DOTS_PER_LINE = DOT_W'(456);
	localparam logic [DOT_W-1:0]  OAM_END       = DOT_W'(80);
	localparam logic [DOT_W-1:0]  DRAW_END      = DOT_W'(252);
	localparam logic [LINE_W-1:0] VBLANK_LINE   = LINE_W'(144);
	localparam logic [LINE_W-1:0] LAST_LINE     = LINE_W'(153);

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} lcd_mode_t;

	typedef struct packed {
		logic [DOT_W-1:0]  dot_count;
		logic [LINE_W-1:0] scan_line;
		lcd_mode_t         current_mode;
		logic              match_sticky;
	} timer_state_t;

	typedef struct packed {
		logic vblank_request;
		logic stat_request;
	} timer_req_t;

endpackage : lsmt_pkg
`default_nettype wire

>>> hw/rtl/lcd_scanline_mode_timer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer: scan-line and mode timer of an LCD controller
// Counts dots, steps scan lines and reports mode, coincidence and interrupt
// requests for every word of elapsed machine cycles.
// ----------------------------------------------------------------------------
// Each input word carries the machine cycles that elapsed (four dots each)
// together with the current line compare value and the compare interrupt
// enable. The block answers every word with exactly one result word holding
// the scan line and mode after the step, the sticky coincidence flag, and
// the vblank and STAT requests raised by that step. The timer takes one word
// per clock cycle while the receiver keeps taking results. A word accepted
// sits in the input register until the result register can load, and then
// its result moves into the result register, which drives the output. The
// rate is set by the timer state update, a loop through the state register
// of one add, one compare against 456 and the line and mode selection. Both
// channels use valid/ready; an input word is taken while the previous result
// still waits, if the input register is empty or is emptied in the same cycle.
// After reset the timer sits at line 0, dot 0, in OAM mode, with the
// coincidence flag clear. The flag is sticky and only reset clears it.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer
	import lsmt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [MC_W-1:0]   machine_cycles,
	input  wire logic [LINE_W-1:0] line_compare,
	input  wire logic              compare_irq_enable,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [LINE_W-1:0]      line_number,
	output logic [1:0]             mode_code,
	output logic                   coincidence_flag,
	output logic                   vblank_request,
	output logic                   stat_request
);

	// Input register stage.
	logic              valid_s1;
	logic [MC_W-1:0]   mc_s1;
	logic [LINE_W-1:0] cmp_s1;
	logic              en_s1;

	// Result register stage.
	logic              valid_s2;
	timer_state_t      res_s2;
	timer_req_t        req_s2;

	// Timer state.
	timer_state_t      state_q;
	timer_state_t      state_nxt;
	timer_req_t        req_nxt;

	logic              advance;

	// The result register can load when it is empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mc_s1  <= machine_cycles;
			cmp_s1 <= line_compare;
			en_s1  <= compare_irq_enable;
		end
	end

	lsmt_step u_step (
		.cur                (state_q),
		.machine_cycles     (mc_s1),
		.line_compare       (cmp_s1),
		.compare_irq_enable (en_s1),
		.nxt                (state_nxt),
		.req                (req_nxt)
	);

	// The state moves only when the word in the input stage is retired
	// into the result register, so every word is applied exactly once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.dot_count    <= '0;
			state_q.scan_line    <= '0;
			state_q.current_mode <= MODE_OAM;
			state_q.match_sticky <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= state_nxt;
			req_s2 <= req_nxt;
		end
	end

	assign out_valid        = valid_s2;
	assign line_number      = res_s2.scan_line;
	assign mode_code        = res_s2.current_mode;
	assign coincidence_flag = res_s2.match_sticky;
	assign vblank_request   = req_s2.vblank_request;
	assign stat_request     = req_s2.stat_request;

	// The dot count of the result word is not a port; it lives on in state_q.
	logic unused_dot;
	assign unused_dot = ^res_s2.dot_count;

endmodule : lcd_scanline_mode_timer
`default_nettype wire

>>> hw/rtl/lsmt_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_step: next-state logic of the scan-line mode timer
// Advances the dot counter for one word, steps and wraps the line, picks the
// mode and forms the line-match and vblank requests.
// ----------------------------------------------------------------------------
module lsmt_step
	import lsmt_pkg::*;
(
	input  timer_state_t      cur,
	input  logic [MC_W-1:0]   machine_cycles,
	input  logic [LINE_W-1:0] line_compare,
	input  logic              compare_irq_enable,
	output timer_state_t      nxt,
	output timer_req_t        req
);

	logic [DOT_W-1:0]  dot_sum;
	logic              wrap;
	logic [DOT_W-1:0]  dot_new;
	logic [LINE_W-1:0] line_inc;
	logic [LINE_W-1:0] line_mid;
	logic              match_inc;
	logic              match_zero;

	always_comb begin
		// At most 28 dots per word, so the sum stays below 512.
		dot_sum  = cur.dot_count + {{(DOT_W-MC_W-2){1'b0}}, machine_cycles, 2'b00};
		wrap     = (dot_sum >= DOTS_PER_LINE);
		dot_new  = wrap ? (dot_sum - DOTS_PER_LINE) : dot_sum;
		line_inc = cur.scan_line + LINE_W'(1);
		line_mid = wrap ? line_inc : cur.scan_line;
		match_inc  = wrap && (line_inc == line_compare);
		match_zero = 1'b0;

		nxt.dot_count    = dot_new;
		nxt.scan_line    = line_mid;
		nxt.current_mode = cur.current_mode;
		req.vblank_request = 1'b0;

		if (line_mid < VBLANK_LINE) begin
			if (dot_new <= OAM_END)
				nxt.current_mode = MODE_OAM;
			else if (dot_new <= DRAW_END)
				nxt.current_mode = MODE_DRAW;
			else
				nxt.current_mode = MODE_HBLANK;
		end

		if (line_mid == VBLANK_LINE) begin
			nxt.current_mode   = MODE_VBLANK;
			req.vblank_request = 1'b1;
		end else if (line_mid > LAST_LINE) begin
			// Frame wrap: line zero is compared as well.
			nxt.current_mode = MODE_OAM;
			nxt.scan_line    = '0;
			match_zero       = (line_compare == '0);
		end

		nxt.match_sticky = cur.match_sticky | match_inc | match_zero;
		req.stat_request = compare_irq_enable & (match_inc | match_zero);
	end

endmodule : lsmt_step
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the scan-line mode timer
// Streams words of elapsed machine cycles into the timer. Line compare values
// are aimed at the lines about to be reached. Every result word is predicted
// from a model of the dot counter, line, mode and coincidence flag, and is
// checked while the sender gaps and the receiver stalls follow several
// patterns.
// ----------------------------------------------------------------------------
module testbench;
	import lsmt_pkg::*;

	// One word of stimulus, as it sits in the pending queue.
	typedef struct packed {
		logic [MC_W-1:0]   cycles;
		logic [LINE_W-1:0] compare;
		logic              irq_en;
	} timer_word_t;

	// The result word the timer should produce for one input word.
	typedef struct packed {
		logic [LINE_W-1:0] line;
		lcd_mode_t         mode;
		logic              coincidence;
		logic              vblank;
		logic              stat;
	} scan_result_t;

	// The random part sends its words in phases of PHASE_WORDS, the phases taking
	// four idling patterns in turn, until at least RANDOM_WORDS words have been queued.
	localparam int RANDOM_WORDS = 1900;
	localparam int PHASE_WORDS  = 240;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [MC_W-1:0]   machine_cycles = '0;
	logic [LINE_W-1:0] line_compare = '0;
	logic              compare_irq_enable = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [LINE_W-1:0] line_number;
	logic [1:0]        mode_code;
	logic              coincidence_flag;
	logic              vblank_request;
	logic              stat_request;

	lcd_scanline_mode_timer DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.machine_cycles     (machine_cycles),
		.line_compare       (line_compare),
		.compare_irq_enable (compare_irq_enable),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.line_number        (line_number),
		.mode_code          (mode_code),
		.coincidence_flag   (coincidence_flag),
		.vblank_request     (vblank_request),
		.stat_request       (stat_request)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Words waiting to be offered, and the results still owed by the timer.
	timer_word_t  pending_words[$];
	scan_result_t expected_scans[$];
	timer_word_t  next_word;
	timer_word_t  seen_word;
	scan_result_t want_scan;

	int words_queued = 0;
	int words_taken = 0;
	int fail_count = 0;
	int dots_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic in_taken = 1'b0;

	// Long receiver hold-off, requested once by the stimulus and counted down
	// by the receiver process itself.
	logic hold_armed = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	// Predicted timer state.
	logic [DOT_W-1:0]  dot_pos = '0;
	logic [LINE_W-1:0] cur_line = '0;
	lcd_mode_t         cur_mode = MODE_OAM;
	logic              line_matched = 1'b0;

	// A line match sets the sticky flag; the request only goes out when the
	// compare interrupt is enabled.
	function automatic logic compare_line(logic [LINE_W-1:0] compare, logic irq_en);
		if (cur_line == compare) begin
			line_matched = 1'b1;
			return irq_en;
		end
		return 1'b0;
	endfunction

	// Advances the predicted timer by one word and returns its result word.
	function automatic scan_result_t advance_scan_timer(timer_word_t w);
		scan_result_t   r;
		logic [DOT_W:0] dots;
		r.vblank = 1'b0;
		r.stat   = 1'b0;
		dots = {1'b0, dot_pos} + {{(DOT_W-MC_W-1){1'b0}}, w.cycles, 2'b00};
		// At most 28 dots come in per word, so one subtraction always brings
		// the count back below a full line.
		if (dots >= {1'b0, DOTS_PER_LINE}) begin
			dots = dots - {1'b0, DOTS_PER_LINE};
			cur_line = cur_line + LINE_W'(1);
			if (compare_line(w.compare, w.irq_en))
				r.stat = 1'b1;
		end
		dot_pos = dots[DOT_W-1:0];
		// Visible lines take their mode from the dot position. Lines 145 to
		// 153 keep whatever mode they already had.
		if (cur_line < VBLANK_LINE) begin
			if (dot_pos <= OAM_END)
				cur_mode = MODE_OAM;
			else if (dot_pos <= DRAW_END)
				cur_mode = MODE_DRAW;
			else
				cur_mode = MODE_HBLANK;
		end
		if (cur_line == VBLANK_LINE) begin
			cur_mode = MODE_VBLANK;
			r.vblank = 1'b1;
		end else if (cur_line > LAST_LINE) begin
			// Line 154 was already compared above; line 0 gets its own compare.
			cur_mode = MODE_OAM;
			cur_line = '0;
			if (compare_line(w.compare, w.irq_en))
				r.stat = 1'b1;
		end
		r.line        = cur_line;
		r.mode        = cur_mode;
		r.coincidence = line_matched;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [LINE_W-1:0] want,
			input logic [LINE_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	task automatic queue_word(input logic [MC_W-1:0] cycles, input logic [LINE_W-1:0] compare,
			input logic irq_en);
		timer_word_t w;
		w.cycles  = cycles;
		w.compare = compare;
		w.irq_en  = irq_en;
		pending_words.push_back(w);
		words_queued++;
		dots_sent += 4 * int'(cycles);
	endtask

	// Driver: inputs change on the falling edge. A word that is on the port
	// stays there, unchanged, until the rising edge that accepts it.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid           <= 1'b0;
			machine_cycles     <= '0;
			line_compare       <= '0;
			compare_irq_enable <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_word = pending_words.pop_front();
				in_valid           <= 1'b1;
				machine_cycles     <= next_word.cycles;
				line_compare       <= next_word.compare;
				compare_irq_enable <= next_word.irq_en;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that lets the timer fill
	// up and push back on the sender.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: on each rising edge it checks a delivered result word against
	// the oldest prediction, and then predicts the result of an accepted input
	// word. A word accepted now cannot leave in the same cycle, so this order
	// is safe.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken     <= 1'b0;
			dot_pos      = '0;
			cur_line     = '0;
			cur_mode     = MODE_OAM;
			line_matched = 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (expected_scans.size() == 0) begin
					$error("unexpected result word: line %0d, mode %0d", line_number,
						mode_code);
					fail_count++;
				end else begin
					want_scan = expected_scans.pop_front();
					check_field("line_number", want_scan.line, line_number);
					check_field("mode_code", LINE_W'(want_scan.mode), LINE_W'(mode_code));
					check_field("coincidence_flag", LINE_W'(want_scan.coincidence),
						LINE_W'(coincidence_flag));
					check_field("vblank_request", LINE_W'(want_scan.vblank),
						LINE_W'(vblank_request));
					check_field("stat_request", LINE_W'(want_scan.stat),
						LINE_W'(stat_request));
				end
			end
			if (in_valid && in_ready) begin
				seen_word = {machine_cycles, line_compare, compare_irq_enable};
				expected_scans.push_back(advance_scan_timer(seen_word));
				words_taken++;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [MC_W-1:0]   cycles;
		logic [LINE_W-1:0] compare;
		int                next_line;
		int                random_sent;
		int                phase;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed walk through the first line. A word with no cycles leaves
		// everything as it is. Then come the last OAM dot (80), the first DRAW
		// dot (84), the last DRAW dot (252) and the first HBLANK dot (256).
		// The compare is set to the current line, which must not match while
		// the line stays put. The end of the line matches with the interrupt
		// enabled. The next word stays on that line and must raise nothing.
		queue_word(3'd0, 8'd255, 1'b1);
		queue_word(3'd7, 8'd0, 1'b1);
		queue_word(3'd7, 8'd0, 1'b1);
		queue_word(3'd6, 8'd0, 1'b1);
		queue_word(3'd1, 8'd0, 1'b1);
		repeat (6) queue_word(3'd7, 8'd0, 1'b0);
		queue_word(3'd1, 8'd0, 1'b1);
		repeat (7) queue_word(3'd7, 8'd0, 1'b1);
		queue_word(3'd1, 8'd1, 1'b1);
		queue_word(3'd7, 8'd1, 1'b1);
		queue_word(3'd7, 8'd255, 1'b0);

		// The first random phase runs with no idling, so the hold-off stalls
		// the timer while the sender keeps offering words.
		hold_armed = 1'b1;
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_WORDS) begin
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 54;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 54;
				end
				default: begin
					send_idle_pct  = 17;
					recv_stall_pct = 17;
				end
			endcase
			repeat (PHASE_WORDS) begin
				// Mostly full steps, the largest machine_cycles value, so many lines get covered.
				// The rest draw every cycle count.
				cycles = ($urandom_range(99) < 85) ? 3'd7 : MC_W'($urandom_range(7));
				// The line the timer will be on after this word, known exactly
				// from the dots sent so far. Aiming the compare there makes the
				// line-change steps hit it often.
				next_line = ((dots_sent + 4 * int'(cycles)) / int'(DOTS_PER_LINE))
					% (int'(LAST_LINE) + 1);
				case ($urandom_range(9))
					0, 1, 2, 3: compare = LINE_W'(next_line);
					4:          compare = LINE_W'(int'(LAST_LINE) + 1);
					default:    compare = LINE_W'($urandom_range(255));
				endcase
				queue_word(cycles, compare, 1'($urandom_range(1)));
				random_sent++;
			end
			while (words_taken != words_queued) @(posedge clk);
			phase++;
		end

		while (words_taken != words_queued || expected_scans.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
